FILE: hdl/obpt_pkg.sv
// Shared types and constants for the oriented box point test.
// Holds quaternion and rotation coefficient widths and configuration register indexes.
// No dependencies.
package obpt_pkg;

  // Quaternion component width (signed fixed point, binary point cancels out)
  localparam int QUAT_W  = 16;
  // Product of two quaternion components
  localparam int QPROD_W = 2 * QUAT_W;
  // Rotation coefficient: 2*(a*b +/- c*d), magnitude up to 2^32
  localparam int RCOEF_W = QPROD_W + 2;
  // Squared norm w^2+x^2+y^2+z^2, up to 2^32
  localparam int NORM_W  = QPROD_W + 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z      = 3'd6;
  localparam int CFG_DATA_W = 4 * QUAT_W;

  // Unnormalized rotation matrix, rows in world axes, columns in box axes
  typedef struct packed {
    logic signed [RCOEF_W-1:0] r00;
    logic signed [RCOEF_W-1:0] r01;
    logic signed [RCOEF_W-1:0] r02;
    logic signed [RCOEF_W-1:0] r10;
    logic signed [RCOEF_W-1:0] r11;
    logic signed [RCOEF_W-1:0] r12;
    logic signed [RCOEF_W-1:0] r20;
    logic signed [RCOEF_W-1:0] r21;
    logic signed [RCOEF_W-1:0] r22;
  } rot_t;

endpackage

FILE: hdl/obpt_coeff.sv
// Derives the unnormalized rotation matrix and scaled size bounds from configuration.
// Three free-running register stages: component products, matrix and norm, norm times size.
// Depends on obpt_pkg.
module obpt_coeff #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                      clk,
  input  logic [obpt_pkg::CFG_DATA_W-1:0]           orientation,
  input  logic [COORD_WIDTH-1:0]                    size_x,
  input  logic [COORD_WIDTH-1:0]                    size_y,
  input  logic [COORD_WIDTH-1:0]                    size_z,
  output obpt_pkg::rot_t                            rot,
  output logic [obpt_pkg::NORM_W+COORD_WIDTH-1:0]   bound_x,
  output logic [obpt_pkg::NORM_W+COORD_WIDTH-1:0]   bound_y,
  output logic [obpt_pkg::NORM_W+COORD_WIDTH-1:0]   bound_z
);
  import obpt_pkg::*;

  logic signed [QUAT_W-1:0] qw, qx, qy, qz;
  logic signed [QPROD_W-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  logic [NORM_W-1:0] norm;

  assign qw = $signed(orientation[QUAT_W-1:0]);
  assign qx = $signed(orientation[2*QUAT_W-1:QUAT_W]);
  assign qy = $signed(orientation[3*QUAT_W-1:2*QUAT_W]);
  assign qz = $signed(orientation[4*QUAT_W-1:3*QUAT_W]);

  // Component products
  always_ff @(posedge clk) begin
    ww <= qw * qw;
    xx <= qx * qx;
    yy <= qy * qy;
    zz <= qz * qz;
    xy <= qx * qy;
    wz <= qw * qz;
    xz <= qx * qz;
    wy <= qw * qy;
    yz <= qy * qz;
    wx <= qw * qx;
  end

  // Matrix entries and squared norm
  always_ff @(posedge clk) begin
    rot.r00 <= RCOEF_W'(ww) + RCOEF_W'(xx) - RCOEF_W'(yy) - RCOEF_W'(zz);
    rot.r11 <= RCOEF_W'(ww) - RCOEF_W'(xx) + RCOEF_W'(yy) - RCOEF_W'(zz);
    rot.r22 <= RCOEF_W'(ww) - RCOEF_W'(xx) - RCOEF_W'(yy) + RCOEF_W'(zz);
    rot.r01 <= (RCOEF_W'(xy) - RCOEF_W'(wz)) <<< 1;
    rot.r10 <= (RCOEF_W'(xy) + RCOEF_W'(wz)) <<< 1;
    rot.r02 <= (RCOEF_W'(xz) + RCOEF_W'(wy)) <<< 1;
    rot.r20 <= (RCOEF_W'(xz) - RCOEF_W'(wy)) <<< 1;
    rot.r12 <= (RCOEF_W'(yz) - RCOEF_W'(wx)) <<< 1;
    rot.r21 <= (RCOEF_W'(yz) + RCOEF_W'(wx)) <<< 1;
    norm    <= NORM_W'(unsigned'(ww)) + NORM_W'(unsigned'(xx))
             + NORM_W'(unsigned'(yy)) + NORM_W'(unsigned'(zz));
  end

  // Scaled full sizes
  always_ff @(posedge clk) begin
    bound_x <= (NORM_W+COORD_WIDTH)'(norm) * (NORM_W+COORD_WIDTH)'(size_x);
    bound_y <= (NORM_W+COORD_WIDTH)'(norm) * (NORM_W+COORD_WIDTH)'(size_y);
    bound_z <= (NORM_W+COORD_WIDTH)'(norm) * (NORM_W+COORD_WIDTH)'(size_z);
  end

endmodule

FILE: hdl/oriented_box_point_test_3d_unit.sv
// Datapath: five register stages from input transfer to result in the output register.
// Throughput: one point per cycle while out_stall is low; the five-stage datapath takes a new
// point every cycle unless the output stalls, and bubbles collapse under output stall.
// Reset: synchronous, clears valid bits and loads configuration defaults (identity
// orientation, zero center and size). Derived box coefficients settle through the coefficient
// register stages after a configuration write or reset.
module oriented_box_point_test_3d_unit #(
  parameter int COORD_WIDTH    = 24,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [obpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [obpt_pkg::CFG_DATA_W-1:0]     cfg_data,
  // point input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       point_x,
  input  logic signed [COORD_WIDTH-1:0]       point_y,
  input  logic signed [COORD_WIDTH-1:0]       point_z,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                inside_res
);
  import obpt_pkg::*;

  localparam int DIFF_W  = COORD_WIDTH + 1;          // point - center
  localparam int PROD_W  = RCOEF_W + DIFF_W;         // coefficient times offset
  localparam int LOCAL_W = PROD_W + 2;               // sum of three products
  localparam int BOUND_W = NORM_W + COORD_WIDTH;     // norm times size
  localparam int CMP_W   = LOCAL_W + 1;              // doubled magnitude
  localparam int NSTAGE  = 5;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0]         orientation;
  logic signed [COORD_WIDTH-1:0] center [3];
  logic [COORD_WIDTH-1:0]        size_x, size_y, size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= CFG_DATA_W'(1) << QUAT_FRAC_BITS;
      center[0]   <= '0;
      center[1]   <= '0;
      center[2]   <= '0;
      size_x      <= '0;
      size_y      <= '0;
      size_z      <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ORIENTATION: orientation <= cfg_data;
        REG_CENTER_X:    center[0]   <= $signed(cfg_data[COORD_WIDTH-1:0]);
        REG_CENTER_Y:    center[1]   <= $signed(cfg_data[COORD_WIDTH-1:0]);
        REG_CENTER_Z:    center[2]   <= $signed(cfg_data[COORD_WIDTH-1:0]);
        REG_SIZE_X:      size_x      <= cfg_data[COORD_WIDTH-1:0];
        REG_SIZE_Y:      size_y      <= cfg_data[COORD_WIDTH-1:0];
        REG_SIZE_Z:      size_z      <= cfg_data[COORD_WIDTH-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Rotation matrix (scaled by |q|^2) and bounds n*size, three register stages deep.
  // A point needs the matrix at stage 3 and the bounds at stage 5, so both have
  // settled by then for any point transferred after the write.
  rot_t              rot;
  logic [BOUND_W-1:0] bound [3];

  obpt_coeff #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_coeff (
    .clk         (clk),
    .orientation (orientation),
    .size_x      (size_x),
    .size_y      (size_y),
    .size_z      (size_z),
    .rot         (rot),
    .bound_x     (bound[0]),
    .bound_y     (bound[1]),
    .bound_z     (bound[2])
  );

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its successor loads,
  // so bubbles are squeezed out even while the output waits.
  // ---------------------------------------------------------------------------
  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] adv;
  logic            in_xfer;

  always_comb begin
    adv[NSTAGE] = !vld[NSTAGE] || !out_stall;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  // Hold off input during reset so no transfer is lost.
  assign in_stall = rst || !adv[1];
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= in_xfer;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: capture the point
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] pt [3];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pt[0] <= point_x;
      pt[1] <= point_y;
      pt[2] <= point_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: offset from the box center
  // ---------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] dlt [3];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        dlt[i] <= DIFF_W'(pt[i]) - DIFF_W'(center[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: nine products of the transposed matrix with the offset.
  // prd[3*a + i] is the term for box axis a and world axis i.
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prd [9];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      prd[0] <= rot.r00 * dlt[0];
      prd[1] <= rot.r10 * dlt[1];
      prd[2] <= rot.r20 * dlt[2];
      prd[3] <= rot.r01 * dlt[0];
      prd[4] <= rot.r11 * dlt[1];
      prd[5] <= rot.r21 * dlt[2];
      prd[6] <= rot.r02 * dlt[0];
      prd[7] <= rot.r12 * dlt[1];
      prd[8] <= rot.r22 * dlt[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: box-axis offset scaled by |q|^2
  // ---------------------------------------------------------------------------
  logic signed [LOCAL_W-1:0] loc [3];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int a = 0; a < 3; a++) begin
        loc[a] <= LOCAL_W'(prd[3*a]) + LOCAL_W'(prd[3*a+1]) + LOCAL_W'(prd[3*a+2]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: inclusive bound test 2*|local| <= n*size on every axis
  // ---------------------------------------------------------------------------
  logic [LOCAL_W-1:0] mag [3];
  logic [2:0]         axis_pass;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a]       = loc[a][LOCAL_W-1] ? LOCAL_W'(-loc[a]) : LOCAL_W'(loc[a]);
      axis_pass[a] = ({mag[a], 1'b0} <= CMP_W'(bound[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NSTAGE]) begin
      inside_res <= &axis_pass;
    end
  end

  assign out_valid = vld[NSTAGE];

endmodule
